@@ hw/rtl/lrt_pkg.sv @@
// lrt_pkg: shared types, constants, saturation helpers and the sigmoid table
// for the logistic regression trainer; no dependencies
`default_nettype none

package lrt_pkg;

   // sizes
   localparam int MAX_FEATURES = 16;
   localparam int FEAT_W       = $clog2(MAX_FEATURES);
   localparam int MAX_SAMPLES  = 1024;
   localparam int SAMP_W       = $clog2(MAX_SAMPLES);
   localparam int CNT_W        = $clog2(MAX_SAMPLES + 1);
   localparam int SADDR_W      = SAMP_W + FEAT_W;
   localparam int SIG_DEPTH    = 256;
   localparam int SIG_IDX_W    = $clog2(SIG_DEPTH);
   localparam int SPAN_BITS    = 27;
   localparam int TAB_W        = 25;

   // field widths
   localparam int DATA_W  = 32;
   localparam int IDX_W   = 5;
   localparam int LABEL_W = 25;
   localparam int EPOCH_W = 16;
   localparam int RATE_W  = 24;
   localparam int GRAD_W  = 48;
   localparam int E_W     = 26;
   localparam int ACC_W   = 45;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 24;
   localparam int DIV_CNT_W = $clog2(GRAD_W + 1);

   localparam logic [EPOCH_W-1:0] EPOCH_RESET = 16'd100;
   localparam logic [RATE_W-1:0]  RATE_RESET  = 24'd167772;
   localparam logic [IDX_W-1:0]   FEAT_RESET  = 5'd16;
   localparam logic signed [E_W:0] ONE_Q24    = 27'sd16777216;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EPOCHS   = 2'd0,
      CSR_RATE     = 2'd1,
      CSR_FEATURES = 2'd2
   } csr_reg_type;

   // controller states
   typedef enum logic [4:0] {
      ST_IDLE, ST_START, ST_EPOCH, ST_ROW,
      ST_D_RD, ST_D_MUL, ST_D_ACC,
      ST_SIG_A, ST_SIG_B, ST_SIG_C,
      ST_G_RD, ST_G_MUL, ST_G_ACC, ST_BGRD,
      ST_U_START, ST_U_WAIT, ST_U_HI, ST_U_LO, ST_U_WR,
      ST_EMIT_LD, ST_EMIT_WAIT
   } ctrl_state_type;

   // datapath operations
   typedef enum logic [4:0] {
      OP_NONE, OP_CLR, OP_DOT_INIT, OP_READ, OP_DOT_MUL, OP_DOT_ACC,
      OP_SIG_A, OP_SIG_B, OP_SIG_C, OP_GRD_MUL, OP_GRD_ACC, OP_BGRD,
      OP_DIV_START, OP_STEP_HI, OP_STEP_LO, OP_UPD, OP_EMIT, OP_FIN
   } dp_op_type;

   typedef struct packed {
      dp_op_type          op;
      logic               load;
      logic [IDX_W-1:0]   col;
      logic [SAMP_W-1:0]  row;
      logic [IDX_W-1:0]   feat;
      logic [RATE_W-1:0]  rate;
   } dp_cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] sample_count;
      logic             div_done;
   } dp_stat_type;

   typedef logic [SIG_DEPTH:0][TAB_W-1:0] sig_tab_type;

   function automatic logic signed [DATA_W-1:0] sat_to_32(input logic signed [63:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = v[DATA_W-1:0];
      return r;
   endfunction

   function automatic logic signed [GRAD_W-1:0] sat_to_48(input logic signed [63:0] v);
      logic signed [GRAD_W-1:0] r;
      if (v > 64'sd140737488355327) r = 48'sh7FFFFFFFFFFF;
      else if (v < -64'sd140737488355328) r = 48'sh800000000000;
      else r = v[GRAD_W-1:0];
      return r;
   endfunction

   // shift and subtract division, used only while building the table
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = num;
      for (int b = 0; b < 64; b++) begin
         rem = {rem[63:0], quo[63]};
         quo = {quo[62:0], 1'b0};
         if (rem >= {1'b0, den}) begin
            rem = rem - {1'b0, den};
            quo[0] = 1'b1;
         end
      end
      return quo;
   endfunction

   // exp(-x) in Q0.30 for x in Q8.24 over [0, 8]
   function automatic logic [63:0] exp_neg(input logic [63:0] xq);
      logic [63:0] y;
      logic [63:0] term;
      logic signed [63:0] sum;
      logic [63:0] r;
      y = xq << 2;
      term = 64'd1 << 30;
      sum = 64'sd1 << 30;
      for (int n = 1; n <= 12; n++) begin
         term = udiv64((term * y) >> 30, 64'(n));
         if ((n % 2) == 1) sum = sum - $signed(term);
         else sum = sum + $signed(term);
      end
      if (sum < 0) sum = 0;
      if (sum > (64'sd1 << 30)) sum = 64'sd1 << 30;
      r = sum;
      for (int n = 0; n < 4; n++) r = (r * r + (64'd1 << 29)) >> 30;
      return r;
   endfunction

   function automatic sig_tab_type build_sig_tab();
      sig_tab_type t;
      logic [63:0] x;
      logic [63:0] den;
      for (int k = 0; k <= SIG_DEPTH; k++) begin
         x = (64'(k) << SPAN_BITS) / SIG_DEPTH;
         den = (64'd1 << 30) + exp_neg(x);
         t[k] = TAB_W'(udiv64((64'd1 << 54) + (den >> 1), den));
      end
      return t;
   endfunction

   localparam sig_tab_type SIG_TAB = build_sig_tab();

endpackage

`default_nettype wire

@@ hw/rtl/lrt_ram.sv @@
// lrt_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module lrt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/lrt_div.sv @@
// lrt_div: restoring divider, one quotient bit per cycle, gradient by sample count
// depends on lrt_pkg
`default_nettype none

module lrt_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [lrt_pkg::GRAD_W-1:0]  dividend,
   input  wire logic [lrt_pkg::CNT_W-1:0]   divisor,
   output logic      [lrt_pkg::GRAD_W-1:0]  quotient,
   output logic                             done
);
   import lrt_pkg::*;

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [GRAD_W-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]     den_ff, den_in;
   logic [CNT_W:0]       trial;

   // load on start, else one restoring step while busy
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      trial   = {rem_ff, quo_ff[GRAD_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(GRAD_W);
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = CNT_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[GRAD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[CNT_W-1:0];
            quo_in = {quo_ff[GRAD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient = quo_ff;
   assign done     = !busy_ff;

endmodule

`default_nettype wire

@@ hw/rtl/lrt_dp.sv @@
// lrt_dp: datapath of the trainer: sample and label rams, weights, gradients,
// dot product, sigmoid interpolation and update; depends on lrt_pkg, lrt_ram, lrt_div
`default_nettype none

module lrt_dp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire lrt_pkg::dp_cmd_type               cmd,
   input  wire logic                              req_type,
   input  wire logic signed [lrt_pkg::DATA_W-1:0] req_data_value,
   input  wire logic [lrt_pkg::IDX_W-1:0]         req_weight_index,
   input  wire logic [lrt_pkg::LABEL_W-1:0]       req_label,
   input  wire logic                              req_row_end,
   output lrt_pkg::dp_stat_type                   stat,
   output logic [lrt_pkg::IDX_W-1:0]              rsp_result_index,
   output logic signed [lrt_pkg::DATA_W-1:0]      rsp_result_value,
   output logic                                   rsp_result_last
);
   import lrt_pkg::*;

   localparam int IP_W = TAB_W + SPAN_BITS;
   localparam int POS_W = SPAN_BITS + SIG_IDX_W;

   // load side state
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] col_ff, col_in;

   // model state
   logic signed [DATA_W-1:0] w_ff [MAX_FEATURES];
   logic signed [DATA_W-1:0] bias_ff;
   logic signed [GRAD_W-1:0] g_ff [MAX_FEATURES];
   logic signed [GRAD_W-1:0] bg_ff;

   // working registers
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [63:0]       prod_ff;
   logic                     big_ff, zneg_ff, down_ff;
   logic [TAB_W-1:0]         t0_ff, diff_ff;
   logic [SPAN_BITS-1:0]     fr_ff;
   logic [IP_W-1:0]          ip_ff;
   logic signed [E_W-1:0]    e_ff;
   logic                     neg_ff;
   logic [2*RATE_W-1:0]      phi_ff, plo_ff;
   logic [IDX_W-1:0]         out_idx_ff;
   logic signed [DATA_W-1:0] out_val_ff;
   logic                     out_last_ff;

   // ram ports
   logic                s_wr_en, l_wr_en;
   logic [SADDR_W-1:0]  s_wr_addr, s_rd_addr;
   logic [DATA_W-1:0]   s_q;
   logic [LABEL_W-1:0]  l_q;
   logic                div_done;
   logic [GRAD_W-1:0]   div_q;

   logic [FEAT_W-1:0]   jj;
   logic                sel_bias;
   logic signed [DATA_W-1:0] cur_val;
   logic signed [GRAD_W-1:0] cur_grad;
   logic [GRAD_W-1:0]   grad_mag;

   assign jj       = cmd.col[FEAT_W-1:0];
   assign sel_bias = (cmd.col == cmd.feat);
   assign cur_val  = sel_bias ? bias_ff : w_ff[jj];
   assign cur_grad = sel_bias ? bg_ff : g_ff[jj];
   assign grad_mag = cur_grad[GRAD_W-1] ? GRAD_W'(-cur_grad) : GRAD_W'(cur_grad);

   // load addressing
   logic samp_room;
   assign samp_room = (cnt_ff < CNT_W'(MAX_SAMPLES));
   assign s_wr_en   = cmd.load && req_type && samp_room && (col_ff < cmd.feat);
   assign s_wr_addr = {cnt_ff[SAMP_W-1:0], col_ff[FEAT_W-1:0]};
   assign l_wr_en   = cmd.load && req_type && req_row_end && samp_room;
   assign s_rd_addr = {cmd.row, jj};

   lrt_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SAMPLES * MAX_FEATURES)) u_sample_ram (
      .clock   (clock),
      .wr_en   (s_wr_en),
      .wr_addr (s_wr_addr),
      .wr_data (req_data_value),
      .rd_en   (cmd.op == OP_READ),
      .rd_addr (s_rd_addr),
      .rd_data (s_q)
   );

   lrt_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_SAMPLES)) u_label_ram (
      .clock   (clock),
      .wr_en   (l_wr_en),
      .wr_addr (cnt_ff[SAMP_W-1:0]),
      .wr_data (req_label),
      .rd_en   (cmd.op == OP_DOT_INIT),
      .rd_addr (cmd.row),
      .rd_data (l_q)
   );

   lrt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == OP_DIV_START),
      .dividend (grad_mag),
      .divisor  (cnt_ff),
      .quotient (div_q),
      .done     (div_done)
   );

   // sample count and column position
   always_comb begin
      cnt_in = cnt_ff;
      col_in = col_ff;
      if (cmd.op == OP_FIN) begin
         cnt_in = '0;
         col_in = '0;
      end else if (cmd.load && req_type) begin
         if (col_ff != '1) col_in = col_ff + 1'b1;
         if (req_row_end) begin
            if (samp_room) cnt_in = cnt_ff + 1'b1;
            col_in = '0;
         end
      end
   end

   // dot product term and sigmoid front end
   logic signed [63:0]       dot_term;
   logic signed [DATA_W-1:0] z;
   logic [DATA_W:0]          za;
   logic [POS_W-1:0]         pos;
   logic [SIG_IDX_W:0]       tidx;
   logic [TAB_W-1:0]         t0, t1;

   assign dot_term = prod_ff >>> 24;
   assign z        = sat_to_32(64'(acc_ff));
   assign za       = z[DATA_W-1] ? (DATA_W+1)'(-$signed({z[DATA_W-1], z}))
                                 : {1'b0, z};
   assign pos      = {za[SPAN_BITS-1:0], {SIG_IDX_W{1'b0}}};
   assign tidx     = {1'b0, pos[POS_W-1:SPAN_BITS]};
   assign t0       = SIG_TAB[tidx];
   assign t1       = SIG_TAB[tidx + 1'b1];

   // sigmoid back end and error
   logic [TAB_W-1:0]       delta, s_val;
   logic signed [E_W:0]    p_val, e_full;
   assign delta  = ip_ff[IP_W-1:SPAN_BITS];
   assign s_val  = big_ff ? SIG_TAB[SIG_DEPTH] : (down_ff ? t0_ff - delta : t0_ff + delta);
   assign p_val  = zneg_ff ? ONE_Q24 - $signed({2'b00, s_val}) : $signed({2'b00, s_val});
   assign e_full = p_val - $signed({2'b00, l_q});

   // update step
   logic [GRAD_W:0]     step;
   logic signed [63:0]  upd_in;
   assign step   = {1'b0, phi_ff} + (GRAD_W+1)'(plo_ff >> RATE_W);
   assign upd_in = neg_ff ? 64'(cur_val) + 64'(step) : 64'(cur_val) - 64'(step);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         col_ff  <= '0;
         bias_ff <= '0;
         bg_ff   <= '0;
         for (int k = 0; k < MAX_FEATURES; k++) begin
            w_ff[k] <= '0;
            g_ff[k] <= '0;
         end
      end else begin
         cnt_ff <= cnt_in;
         col_ff <= col_in;
         // starting weight and bias loads
         if (cmd.load && !req_type) begin
            if (req_weight_index < cmd.feat) begin
               w_ff[req_weight_index[FEAT_W-1:0]] <= req_data_value;
            end else if (req_weight_index == cmd.feat) begin
               bias_ff <= req_data_value;
            end
         end
         unique case (cmd.op)
            OP_CLR: begin
               bg_ff <= '0;
               for (int k = 0; k < MAX_FEATURES; k++) g_ff[k] <= '0;
            end
            OP_GRD_ACC: g_ff[jj] <= sat_to_48(64'(g_ff[jj]) + dot_term);
            OP_BGRD:    bg_ff <= sat_to_48(64'(bg_ff) + 64'(e_ff));
            OP_UPD: begin
               if (sel_bias) bias_ff <= sat_to_32(upd_in);
               else w_ff[jj] <= sat_to_32(upd_in);
            end
            default: ;
         endcase
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_DOT_INIT: acc_ff <= ACC_W'(bias_ff);
         OP_DOT_MUL:  prod_ff <= 64'(w_ff[jj]) * 64'($signed(s_q));
         OP_DOT_ACC:  acc_ff <= acc_ff + dot_term[ACC_W-1:0];
         OP_SIG_A: begin
            zneg_ff <= z[DATA_W-1];
            big_ff  <= |za[DATA_W:SPAN_BITS];
            t0_ff   <= t0;
            down_ff <= (t1 < t0);
            diff_ff <= (t1 < t0) ? t0 - t1 : t1 - t0;
            fr_ff   <= pos[SPAN_BITS-1:0];
         end
         OP_SIG_B:   ip_ff <= IP_W'(diff_ff) * IP_W'(fr_ff);
         OP_SIG_C:   e_ff <= e_full[E_W-1:0];
         OP_GRD_MUL: prod_ff <= 64'(e_ff) * 64'($signed(s_q));
         OP_DIV_START: neg_ff <= cur_grad[GRAD_W-1];
         OP_STEP_HI: phi_ff <= (2*RATE_W)'(div_q[GRAD_W-1:RATE_W]) * (2*RATE_W)'(cmd.rate);
         OP_STEP_LO: plo_ff <= (2*RATE_W)'(div_q[RATE_W-1:0]) * (2*RATE_W)'(cmd.rate);
         OP_EMIT: begin
            out_idx_ff  <= cmd.col;
            out_val_ff  <= cur_val;
            out_last_ff <= sel_bias;
         end
         default: ;
      endcase
   end

   assign stat.sample_count = cnt_ff;
   assign stat.div_done     = div_done;
   assign rsp_result_index  = out_idx_ff;
   assign rsp_result_value  = out_val_ff;
   assign rsp_result_last   = out_last_ff;

endmodule

`default_nettype wire

@@ hw/rtl/lrt_ctrl.sv @@
// lrt_ctrl: control state machine, loop counters and configuration registers
// of the trainer; depends on lrt_pkg
`default_nettype none

module lrt_ctrl (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_set_end,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [lrt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [lrt_pkg::CSR_DATA_W-1:0]    csr_data,
   input  wire lrt_pkg::dp_stat_type              stat,
   output lrt_pkg::dp_cmd_type                    cmd
);
   import lrt_pkg::*;

   ctrl_state_type     state_ff, state_in;
   logic [IDX_W-1:0]   j_ff, j_in;
   logic [SAMP_W-1:0]  i_ff, i_in;
   logic [EPOCH_W-1:0] ep_ff, ep_in;
   logic [EPOCH_W-1:0] epochs_ff;
   logic [RATE_W-1:0]  rate_ff;
   logic [IDX_W-1:0]   feat_ff;
   logic [IDX_W-1:0]   d;
   logic               j_last, row_last, at_bias;

   // feature count clamped to the supported range
   always_comb begin
      priority if (feat_ff == '0) d = IDX_W'(1);
      else if (feat_ff > IDX_W'(MAX_FEATURES)) d = IDX_W'(MAX_FEATURES);
      else d = feat_ff;
   end

   assign j_last   = (j_ff + 1'b1 == d);
   assign at_bias  = (j_ff == d);
   assign row_last = ({1'b0, i_ff} + 1'b1 == stat.sample_count);

   // next state
   always_comb begin
      state_in = state_ff;
      j_in     = j_ff;
      i_in     = i_ff;
      ep_in    = ep_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid && req_set_end) state_in = ST_START;
         ST_START: begin
            j_in  = '0;
            ep_in = '0;
            if (stat.sample_count == '0 || epochs_ff == '0) state_in = ST_EMIT_LD;
            else state_in = ST_EPOCH;
         end
         ST_EPOCH: begin
            i_in     = '0;
            state_in = ST_ROW;
         end
         ST_ROW: begin
            j_in     = '0;
            state_in = ST_D_RD;
         end
         ST_D_RD:  state_in = ST_D_MUL;
         ST_D_MUL: state_in = ST_D_ACC;
         ST_D_ACC: begin
            if (j_last) begin
               j_in     = '0;
               state_in = ST_SIG_A;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = ST_D_RD;
            end
         end
         ST_SIG_A: state_in = ST_SIG_B;
         ST_SIG_B: state_in = ST_SIG_C;
         ST_SIG_C: state_in = ST_G_RD;
         ST_G_RD:  state_in = ST_G_MUL;
         ST_G_MUL: state_in = ST_G_ACC;
         ST_G_ACC: begin
            if (j_last) begin
               state_in = ST_BGRD;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = ST_G_RD;
            end
         end
         ST_BGRD: begin
            j_in = '0;
            if (row_last) begin
               state_in = ST_U_START;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_ROW;
            end
         end
         ST_U_START: state_in = ST_U_WAIT;
         ST_U_WAIT:  if (stat.div_done) state_in = ST_U_HI;
         ST_U_HI:    state_in = ST_U_LO;
         ST_U_LO:    state_in = ST_U_WR;
         ST_U_WR: begin
            if (at_bias) begin
               j_in = '0;
               if (ep_ff + 1'b1 == epochs_ff) begin
                  state_in = ST_EMIT_LD;
               end else begin
                  ep_in    = ep_ff + 1'b1;
                  state_in = ST_EPOCH;
               end
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = ST_U_START;
            end
         end
         ST_EMIT_LD: state_in = ST_EMIT_WAIT;
         ST_EMIT_WAIT: begin
            if (rsp_ready) begin
               if (at_bias) begin
                  state_in = ST_IDLE;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = ST_EMIT_LD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath commands
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_EMIT_WAIT);
      csr_ready = 1'b1;
      cmd.load  = (state_ff == ST_IDLE) && req_valid;
      cmd.col   = j_ff;
      cmd.row   = i_ff;
      cmd.feat  = d;
      cmd.rate  = rate_ff;
      unique case (state_ff)
         ST_EPOCH:     cmd.op = OP_CLR;
         ST_ROW:       cmd.op = OP_DOT_INIT;
         ST_D_RD:      cmd.op = OP_READ;
         ST_D_MUL:     cmd.op = OP_DOT_MUL;
         ST_D_ACC:     cmd.op = OP_DOT_ACC;
         ST_SIG_A:     cmd.op = OP_SIG_A;
         ST_SIG_B:     cmd.op = OP_SIG_B;
         ST_SIG_C:     cmd.op = OP_SIG_C;
         ST_G_RD:      cmd.op = OP_READ;
         ST_G_MUL:     cmd.op = OP_GRD_MUL;
         ST_G_ACC:     cmd.op = OP_GRD_ACC;
         ST_BGRD:      cmd.op = OP_BGRD;
         ST_U_START:   cmd.op = OP_DIV_START;
         ST_U_HI:      cmd.op = OP_STEP_HI;
         ST_U_LO:      cmd.op = OP_STEP_LO;
         ST_U_WR:      cmd.op = OP_UPD;
         ST_EMIT_LD:   cmd.op = OP_EMIT;
         ST_EMIT_WAIT: cmd.op = (rsp_ready && at_bias) ? OP_FIN : OP_NONE;
         default:      cmd.op = OP_NONE;
      endcase
   end

   // state, counters and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         j_ff      <= '0;
         i_ff      <= '0;
         ep_ff     <= '0;
         epochs_ff <= EPOCH_RESET;
         rate_ff   <= RATE_RESET;
         feat_ff   <= FEAT_RESET;
      end else begin
         state_ff <= state_in;
         j_ff     <= j_in;
         i_ff     <= i_in;
         ep_ff    <= ep_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_EPOCHS:   epochs_ff <= csr_data[EPOCH_W-1:0];
               CSR_RATE:     rate_ff   <= csr_data[RATE_W-1:0];
               CSR_FEATURES: feat_ff   <= csr_data[IDX_W-1:0];
               default: ;
            endcase
         end
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/logistic_regression_trainer_core.sv @@
// logistic_regression_trainer_core: top level joining controller and datapath
// depends on lrt_pkg, lrt_ctrl, lrt_dp
//
// Usage:
//  - csr channel writes epoch_count (0), learning_rate (1), feature_count (2);
//    csr_ready is always high, write only while the block is idle
//  - req channel takes weight/bias loads and feature values, one transaction
//    per cycle while idle; samples go to an on-chip ram of 1024 rows x 16
//  - the transaction with set_end starts training; req_ready stays low until
//    the last result is taken
//  - in each epoch over n rows and d features, each element is read,
//    multiplied and accumulated in sequence, and each update waits on a
//    bit serial divider
//  - then d+1 results come out on rsp, weights first, bias last with
//    result_last set; the next one is loaded once the current is taken
//  - a stalled receiver holds the current result and the block waits
//  - reset clears weights, bias, counters and the configuration to defaults;
//    sample and label rams are not cleared
`default_nettype none

module logistic_regression_trainer_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_type,
   input  wire logic signed [lrt_pkg::DATA_W-1:0] req_data_value,
   input  wire logic [lrt_pkg::IDX_W-1:0]         req_weight_index,
   input  wire logic [lrt_pkg::LABEL_W-1:0]       req_label,
   input  wire logic                              req_row_end,
   input  wire logic                              req_set_end,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [lrt_pkg::IDX_W-1:0]              rsp_result_index,
   output logic signed [lrt_pkg::DATA_W-1:0]      rsp_result_value,
   output logic                                   rsp_result_last,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [lrt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [lrt_pkg::CSR_DATA_W-1:0]    csr_data
);
   import lrt_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   lrt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_set_end (req_set_end),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .stat        (stat),
      .cmd         (cmd)
   );

   lrt_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_type         (req_type),
      .req_data_value   (req_data_value),
      .req_weight_index (req_weight_index),
      .req_label        (req_label),
      .req_row_end      (req_row_end),
      .stat             (stat),
      .rsp_result_index (rsp_result_index),
      .rsp_result_value (rsp_result_value),
      .rsp_result_last  (rsp_result_last)
   );

endmodule

`default_nettype wire

@@ hw/rtl/lrt_checker.sv @@
// lrt_checker: port level checks of the trainer, bound to the top level
// depends on lrt_pkg
`default_nettype none

module lrt_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_ready,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [lrt_pkg::IDX_W-1:0]         rsp_result_index,
   input wire logic signed [lrt_pkg::DATA_W-1:0] rsp_result_value,
   input wire logic                              rsp_result_last
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_index)
         && $stable(rsp_result_value) && $stable(rsp_result_last))
      else $error("stalled result changed");

   // no input taken while results are pending
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input open during result output");

   // after the bias result the block is idle again
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_result_last |=> req_ready && !rsp_valid)
      else $error("block not idle after last result");

   // results come out in index order
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_result_last |=> !rsp_valid ##1
         (rsp_valid && rsp_result_index == $past(rsp_result_index, 2) + 5'd1))
      else $error("result index out of order");

endmodule

bind logistic_regression_trainer_core lrt_checker u_lrt_checker (.*);

`default_nettype wire

@@ verif/logistic_regression_trainer_checker.sv @@
// logistic_regression_trainer_checker: watches the csr, req and rsp channels,
// predicts trained weights and bias and compares each rsp transaction
// depends on lrt_pkg for widths and register indexes
module logistic_regression_trainer_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_ready,
   input  wire logic                              req_type,
   input  wire logic signed [lrt_pkg::DATA_W-1:0] req_data_value,
   input  wire logic [lrt_pkg::IDX_W-1:0]         req_weight_index,
   input  wire logic [lrt_pkg::LABEL_W-1:0]       req_label,
   input  wire logic                              req_row_end,
   input  wire logic                              req_set_end,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   input  wire logic [lrt_pkg::IDX_W-1:0]         rsp_result_index,
   input  wire logic signed [lrt_pkg::DATA_W-1:0] rsp_result_value,
   input  wire logic                              rsp_result_last,
   input  wire logic                              csr_valid,
   input  wire logic                              csr_ready,
   input  wire logic [lrt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [lrt_pkg::CSR_DATA_W-1:0]    csr_data,
   output int                                     fail_count,
   output int                                     pending,
   output int                                     results_checked,
   output int                                     sets_trained
);
   import lrt_pkg::*;

   localparam longint Q24_ONE  = 64'sd16777216;
   localparam longint Q30_ONE  = 64'sd1073741824;
   localparam longint G48_HIGH = 64'sd140737488355327;
   localparam longint G48_LOW  = -64'sd140737488355328;

   typedef struct {
      logic [IDX_W-1:0]         index;
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } coef_result_t;

   coef_result_t trained_q[$];

   // predictor state
   longint sig_points[0:SIG_DEPTH];
   logic signed [DATA_W-1:0] feature_mem[0:MAX_SAMPLES*MAX_FEATURES-1];
   logic [LABEL_W-1:0]       target_mem[0:MAX_SAMPLES-1];
   longint weights[0:MAX_FEATURES-1];
   longint bias;
   longint grads[0:MAX_FEATURES-1];
   longint bias_grad;
   int     rows_held;
   int     column;
   int     epochs_cfg;
   longint rate_cfg;
   int     features_cfg;
   int     errs, checked, sets;

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint clip48(longint v);
      if (v > G48_HIGH) return G48_HIGH;
      if (v < G48_LOW) return G48_LOW;
      return v;
   endfunction

   // exp(-x) in Q0.30: taylor series of exp(-x/16), then squared four times
   function automatic longint unsigned decay_q30(longint unsigned xq);
      longint unsigned y, term, r;
      longint acc;
      y = xq << 2;
      term = Q30_ONE;
      acc = Q30_ONE;
      for (int n = 1; n <= 12; n++) begin
         term = ((term * y) >> 30) / longint'(n);
         if (n % 2 == 1) acc = acc - longint'(term);
         else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > Q30_ONE) acc = Q30_ONE;
      r = acc;
      for (int n = 0; n < 4; n++) r = (r * r + (64'd1 << 29)) >> 30;
      return r;
   endfunction

   function automatic longint logistic_q24(longint z);
      longint unsigned mag, pos, idx, frac, lo, hi, s;
      mag = (z < 0) ? -z : z;
      if (mag >= (64'd1 << SPAN_BITS)) s = sig_points[SIG_DEPTH];
      else begin
         pos  = mag * SIG_DEPTH;
         idx  = pos >> SPAN_BITS;
         frac = pos & ((64'd1 << SPAN_BITS) - 1);
         lo   = sig_points[idx];
         hi   = sig_points[idx+1];
         if (hi >= lo) s = lo + (((hi - lo) * frac) >> SPAN_BITS);
         else s = lo - (((lo - hi) * frac) >> SPAN_BITS);
      end
      return (z < 0) ? Q24_ONE - longint'(s) : longint'(s);
   endfunction

   function automatic longint rate_step(longint q, longint unsigned lr);
      longint unsigned m, st;
      m  = (q < 0) ? -q : q;
      st = (m >> 24) * lr + (((m & 64'hFFFFFF) * lr) >> 24);
      return (q < 0) ? -longint'(st) : longint'(st);
   endfunction

   // full batch gradient descent over the held rows
   task automatic run_descent(int d);
      longint acc, err, x;
      for (int ep = 0; ep < epochs_cfg && rows_held > 0; ep++) begin
         for (int j = 0; j < MAX_FEATURES; j++) grads[j] = 0;
         bias_grad = 0;
         for (int i = 0; i < rows_held; i++) begin
            acc = bias;
            for (int j = 0; j < d; j++)
               acc += (weights[j] * longint'(feature_mem[i*MAX_FEATURES+j])) >>> 24;
            err = logistic_q24(clip32(acc)) - longint'(target_mem[i]);
            for (int j = 0; j < d; j++) begin
               x = feature_mem[i*MAX_FEATURES+j];
               grads[j] = clip48(grads[j] + ((err * x) >>> 24));
            end
            bias_grad = clip48(bias_grad + err);
         end
         for (int j = 0; j < d; j++)
            weights[j] = clip32(weights[j] - rate_step(grads[j] / rows_held, rate_cfg));
         bias = clip32(bias - rate_step(bias_grad / rows_held, rate_cfg));
      end
   endtask

   // one accepted req transaction
   task automatic absorb_item();
      int d;
      coef_result_t r;
      d = (features_cfg < 1) ? 1 : (features_cfg > MAX_FEATURES) ? MAX_FEATURES : features_cfg;
      if (req_type == 1'b0) begin
         if (req_weight_index < d) weights[req_weight_index] = req_data_value;
         else if (req_weight_index == d) bias = req_data_value;
      end else begin
         if (rows_held < MAX_SAMPLES && column < d)
            feature_mem[rows_held*MAX_FEATURES+column] = req_data_value;
         if (column < 31) column++;
         if (req_row_end) begin
            if (rows_held < MAX_SAMPLES) begin
               target_mem[rows_held] = req_label;
               rows_held++;
            end
            column = 0;
         end
      end
      if (req_set_end) begin
         run_descent(d);
         for (int j = 0; j <= d; j++) begin
            r.index = IDX_W'(j);
            r.value = (j == d) ? bias[DATA_W-1:0] : weights[j][DATA_W-1:0];
            r.last  = (j == d);
            trained_q.push_back(r);
         end
         rows_held = 0;
         column = 0;
         sets++;
      end
   endtask

   task automatic check_result();
      coef_result_t r;
      if (trained_q.size() == 0) begin
         $error("unexpected result transaction: index %0d value %0d",
                rsp_result_index, rsp_result_value);
         errs++;
         return;
      end
      r = trained_q.pop_front();
      checked++;
      if (rsp_result_index !== r.index) begin
         $error("result_index: expected %0d, actual %0d", r.index, rsp_result_index);
         errs++;
      end
      if (rsp_result_value !== r.value) begin
         $error("result_value: expected %0d, actual %0d", r.value, rsp_result_value);
         errs++;
      end
      if (rsp_result_last !== r.last) begin
         $error("result_last: expected %0d, actual %0d", r.last, rsp_result_last);
         errs++;
      end
   endtask

   // sigmoid points over [0, 8.0]
   initial begin
      longint unsigned x, den;
      for (int k = 0; k <= SIG_DEPTH; k++) begin
         x = (longint'(k) << SPAN_BITS) / SIG_DEPTH;
         den = Q30_ONE + decay_q30(x);
         sig_points[k] = ((64'd1 << 54) + den / 2) / den;
      end
      errs = 0;
      checked = 0;
      sets = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < MAX_FEATURES; j++) begin
            weights[j] = 0;
            grads[j] = 0;
         end
         bias = 0;
         bias_grad = 0;
         rows_held = 0;
         column = 0;
         epochs_cfg = EPOCH_RESET;
         rate_cfg = RATE_RESET;
         features_cfg = FEAT_RESET;
         trained_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_result();
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_EPOCHS:   epochs_cfg = csr_data[EPOCH_W-1:0];
               CSR_RATE:     rate_cfg = csr_data[RATE_W-1:0];
               CSR_FEATURES: features_cfg = csr_data[IDX_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) absorb_item();
      end
      fail_count <= errs;
      pending <= trained_q.size();
      results_checked <= checked;
      sets_trained <= sets;
   end
endmodule

@@ verif/logistic_regression_trainer_core_tb.sv @@
// logistic_regression_trainer_core_tb: stimulus, clock, reset and verdict
// depends on lrt_pkg, logistic_regression_trainer_core and the checker
module logistic_regression_trainer_core_tb;
   import lrt_pkg::*;

   localparam int CYCLE_LIMIT = 4000000;
   localparam logic [LABEL_W-1:0] LABEL_ONE = 25'd16777216;

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_type, req_row_end, req_set_end, rsp_ready;
   logic signed [DATA_W-1:0] req_data_value;
   logic [IDX_W-1:0] req_weight_index;
   logic [LABEL_W-1:0] req_label;
   logic csr_valid;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   wire req_ready, rsp_valid, rsp_result_last, csr_ready;
   wire [IDX_W-1:0] rsp_result_index;
   wire signed [DATA_W-1:0] rsp_result_value;
   int fail_count, pending, results_checked, sets_trained;

   // stimulus bookkeeping: which feature cells hold data, to keep short rows legal
   bit cell_filled[0:MAX_SAMPLES-1][0:MAX_FEATURES-1];
   int cur_row, cur_col, width_in_use, items_sent, cycles;
   bit idle_on;

   always #2 clock = ~clock;

   logistic_regression_trainer_core DUT (.*);
   logistic_regression_trainer_checker checker_i (.*);

   // receiver stalls
   always @(posedge clock) rsp_ready <= !idle_on || ($urandom_range(99) >= 16);

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(7))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2, 3: return $urandom;
         default: return $signed($urandom_range(32'h04000000)) - 32'sh02000000;
      endcase
   endfunction

   function automatic logic [LABEL_W-1:0] pick_label();
      case ($urandom_range(5))
         0: return '0;
         1: return LABEL_ONE;
         2: return LABEL_W'($urandom);
         default: return LABEL_W'($urandom_range(LABEL_ONE));
      endcase
   endfunction

   function automatic bit short_row_ok(int len);
      if (cur_row >= MAX_SAMPLES) return 1'b1;
      for (int c = len; c < width_in_use; c++)
         if (!cell_filled[cur_row][c]) return 1'b0;
      return 1'b1;
   endfunction

   task automatic send_item(bit kind, logic signed [DATA_W-1:0] val, logic [IDX_W-1:0] wi,
                            logic [LABEL_W-1:0] lab, bit rend, bit send);
      while (idle_on && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_data_value <= val;
      req_weight_index <= wi;
      req_label <= lab;
      req_row_end <= rend;
      req_set_end <= send;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (kind) begin
         if (cur_row < MAX_SAMPLES && cur_col < width_in_use) cell_filled[cur_row][cur_col] = 1'b1;
         if (cur_col < 31) cur_col++;
         if (rend) begin
            if (cur_row < MAX_SAMPLES) cur_row++;
            cur_col = 0;
         end
      end
      if (send) begin
         cur_row = 0;
         cur_col = 0;
      end
   endtask

   task automatic send_row(int len, logic [LABEL_W-1:0] lab, bit rend, bit send);
      for (int c = 0; c < len; c++)
         send_item(1'b1, pick_value(), IDX_W'($urandom), lab, rend && c == len - 1,
                   send && c == len - 1);
   endtask

   task automatic load_coef(int wi, logic signed [DATA_W-1:0] val, bit send);
      send_item(1'b0, val, IDX_W'(wi), pick_label(), 1'($urandom_range(1)), send);
   endtask

   // hold off until every trained value is back and the block has settled
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic configure(int epochs, int rate, int feats);
      csr_valid <= 1'b1;
      csr_index <= CSR_EPOCHS;
      csr_data <= CSR_DATA_W'(epochs);
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_RATE;
      csr_data <= CSR_DATA_W'(rate);
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_FEATURES;
      csr_data <= CSR_DATA_W'(feats);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      width_in_use = feats;
   endtask

   // one data set of random rows, closed in one of three ways
   task automatic random_set();
      int n, len, style;
      n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
      style = $urandom_range(5);
      if (n == 0 && style < 4) style = 4;
      repeat ($urandom_range(0, 3))
         load_coef(($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(width_in_use),
                   pick_value(), 1'b0);
      for (int r = 0; r < n; r++) begin
         case ($urandom_range(5))
            0: len = $urandom_range(1, width_in_use);
            1: len = width_in_use + $urandom_range(1, 3);
            default: len = width_in_use;
         endcase
         if (len < width_in_use && !short_row_ok(len)) len = width_in_use;
         send_row(len, pick_label(), 1'b1, style < 4 && r == n - 1);
      end
      if (style == 4) load_coef($urandom_range(width_in_use), pick_value(), 1'b1);
      else if (style == 5) send_row($urandom_range(1, width_in_use), pick_label(), 1'b0, 1'b1);
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_type <= 1'b0;
      req_data_value <= '0;
      req_weight_index <= '0;
      req_label <= '0;
      req_row_end <= 1'b0;
      req_set_end <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= CSR_EPOCHS;
      csr_data <= '0;
      cycles <= 0;
      idle_on = 1'b1;
      width_in_use = FEAT_RESET;
      cur_row = 0;
      cur_col = 0;
      items_sent = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extreme loads, an ignored load with row_end, one full row at
      // reset settings, training started by a load
      load_coef(0, 32'sh7FFFFFFF, 1'b0);
      load_coef(1, 32'sh80000000, 1'b0);
      load_coef(16, 32'sh01000000, 1'b0);
      send_item(1'b0, 32'sh12345678, 5'd31, '0, 1'b1, 1'b0);
      send_row(16, LABEL_ONE, 1'b1, 1'b0);
      load_coef(2, 32'shFF000000, 1'b1);
      drain();

      // empty set with the largest epoch count and rate
      configure(16'hFFFF, 24'hFFFFFF, 1);
      load_coef(1, 32'sh80000000, 1'b1);
      drain();

      // overlong row, label above one, then a partial row closing the set
      configure(2, 0, 1);
      send_row(34, 25'h1FFFFFF, 1'b1, 1'b0);
      send_row(1, LABEL_ONE, 1'b0, 1'b1);
      drain();

      // random sets, one stretch without idling
      for (int s = 0; items_sent < 330; s++) begin
         idle_on = !(s >= 8 && s < 14);
         if ($urandom_range(2) == 0 || s == 0) begin
            drain();
            configure(($urandom_range(7) == 0) ? 0 : $urandom_range(1, 4),
                      ($urandom_range(3) == 0) ? 24'hFFFFFF : $urandom_range(24'h3FFFFF),
                      ($urandom_range(4) == 0) ? MAX_FEATURES : $urandom_range(1, 6));
         end
         random_set();
      end
      idle_on = 1'b1;

      drain();
      repeat (50) @(posedge clock);

      $display("sent %0d transactions in %0d data sets, checked %0d trained values",
               items_sent, sets_trained, results_checked);
      $display("covered extreme loads, ignored items, empty sets, short and overlong rows");
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule

@@ filelist.f @@
hw/rtl/lrt_pkg.sv
hw/rtl/lrt_ram.sv
hw/rtl/lrt_div.sv
hw/rtl/lrt_dp.sv
hw/rtl/lrt_ctrl.sv
hw/rtl/logistic_regression_trainer_core.sv
hw/rtl/lrt_checker.sv
verif/logistic_regression_trainer_checker.sv
verif/logistic_regression_trainer_core_tb.sv
